// ----- rtl/blup_pkg.sv -----
// ----------------------------------------------------------------------------
// blup_pkg
// Shared constants, codes, text patterns and control structs for the
// radio link parser.
// ----------------------------------------------------------------------------
`default_nettype none

package blup_pkg;

	// default sizes
	localparam int STORE_BYTES_DEF  = 100;
	localparam int PACKET_BYTES_DEF = 48;

	// input commands
	localparam logic [1:0] CMD_BYTE    = 2'd0;
	localparam logic [1:0] CMD_TICK    = 2'd1;
	localparam logic [1:0] CMD_CLEAN   = 2'd2;
	localparam logic [1:0] CMD_CLR_CNT = 2'd3;

	// handshake steps
	localparam logic [3:0] ST_START      = 4'd0;
	localparam logic [3:0] ST_AT         = 4'd1;
	localparam logic [3:0] ST_AT_OK      = 4'd2;
	localparam logic [3:0] ST_CLOSE      = 4'd3;
	localparam logic [3:0] ST_CLOSE_OK   = 4'd4;
	localparam logic [3:0] ST_QSTAT      = 4'd5;
	localparam logic [3:0] ST_QSTAT_OK   = 4'd6;
	localparam logic [3:0] ST_QNAME      = 4'd7;
	localparam logic [3:0] ST_NEED_NAME  = 4'd8;
	localparam logic [3:0] ST_NO_NAME    = 4'd9;
	localparam logic [3:0] ST_SETNAME    = 4'd10;
	localparam logic [3:0] ST_SETNAME_OK = 4'd11;
	localparam logic [3:0] ST_EXIT       = 4'd12;
	localparam logic [3:0] ST_FINISH     = 4'd13;
	localparam logic [3:0] ST_RESET      = 4'd14;

	// commands to the radio module
	localparam logic [2:0] TX_NONE     = 3'd0;
	localparam logic [2:0] TX_ENTER_AT = 3'd1;
	localparam logic [2:0] TX_SET_STAT = 3'd2;
	localparam logic [2:0] TX_QRY_STAT = 3'd3;
	localparam logic [2:0] TX_QRY_NAME = 3'd4;
	localparam logic [2:0] TX_SET_NAME = 3'd5;
	localparam logic [2:0] TX_EXIT_AT  = 3'd6;

	// LED requests
	localparam logic [1:0] LED_NONE  = 2'd0;
	localparam logic [1:0] LED_CONN  = 2'd1;
	localparam logic [1:0] LED_DISC  = 2'd2;
	localparam logic [1:0] LED_SETUP = 2'd3;

	// frame bytes and densities
	localparam logic [7:0] FRAME_DENS = 8'hA5;
	localparam logic [7:0] FRAME_FIN  = 8'hA6;
	localparam logic [7:0] FRAME_END  = 8'h01;
	localparam logic [7:0] DENS_CODE_LOW = 8'h01;
	localparam logic [7:0] DENS_CODE_MID = 8'h02;
	localparam logic [6:0] DENS_NONE = 7'd0;
	localparam logic [6:0] DENS_LOW  = 7'd30;
	localparam logic [6:0] DENS_MID  = 7'd60;
	localparam logic [6:0] DENS_HIGH = 7'd100;

	// text search window: byte i back from newest sits at [8*i +: 8]
	localparam int WIN_BYTES = 12;
	localparam int WIN_BITS  = 8 * WIN_BYTES;
	typedef logic [WIN_BITS-1:0] win_t;

	// text patterns, first character in the top byte of the pattern
	localparam int NUM_TXT  = 7;
	localparam int T_CONN   = 0;
	localparam int T_DISC   = 1;
	localparam int T_DEVERR = 2;
	localparam int T_OK     = 3;
	localparam int T_ERR    = 4;
	localparam int T_STAT0  = 5;
	localparam int T_DFLT   = 6;

	localparam win_t TXT_TAB [NUM_TXT] = '{
		WIN_BITS'("CONNECTED"),
		WIN_BITS'("DISCONNECTED"),
		WIN_BITS'("DEVICE ERROR"),
		WIN_BITS'({"OK", 8'h0D, 8'h0A}),
		WIN_BITS'({"ERROR", 8'h0D, 8'h0A}),
		WIN_BITS'("AT+STATUS=0"),
		WIN_BITS'(64'h5246_2D43_5241_5A59)   // factory default module name
	};
	localparam int TXT_LEN [NUM_TXT] = '{9, 12, 12, 4, 7, 11, 8};

	// pattern ends at the newest window byte
	function automatic logic txt_hit(input win_t win, input win_t ndl, input int len);
		logic ok;
		ok = 1'b1;
		for (int i = 0; i < WIN_BYTES; i++) begin
			if (i < len && win[8*i +: 8] != ndl[8*i +: 8])
				ok = 1'b0;
		end
		return ok;
	endfunction

	// controller to datapath
	typedef struct packed {
		logic load;
		logic write;
		logic scan_init;
		logic scan_en;
		logic commit;
		logic pkt_ld;
		logic pkt_next;
		logic pkt_done;
	} ctl_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic [1:0] cmd;
		logic       scan_done;
		logic       emit;
		logic       pkt_last;
	} dp_stat_t;

endpackage

`default_nettype wire

// ----- rtl/blup_ram.sv -----
// ----------------------------------------------------------------------------
// blup_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module blup_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 100
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

// ----- rtl/blup_datapath.sv -----
// ----------------------------------------------------------------------------
// blup_datapath
// Byte store, text scanner, handshake step logic, frame decode and result
// registers.
// ----------------------------------------------------------------------------
`default_nettype none

module blup_datapath #(
	parameter int STORE_BYTES  = blup_pkg::STORE_BYTES_DEF,
	parameter int PACKET_BYTES = blup_pkg::PACKET_BYTES_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire blup_pkg::ctl_cmd_t ctl,
	output blup_pkg::dp_stat_t    stat,
	input  wire logic [1:0]       cmd,
	input  wire logic [7:0]       rx_byte,
	output logic      [2:0]       tx_command,
	output logic      [3:0]       setup_step,
	output logic                  setup_done,
	output logic      [1:0]       led_event,
	output logic      [6:0]       heat_density,
	output logic                  read_finish,
	output logic      [7:0]       packet_byte,
	output logic                  packet_valid,
	output logic                  last,
	output logic      [31:0]      packet_count,
	output logic                  rename_requested,
	output logic                  clean_pending
);

	import blup_pkg::*;

	localparam int FW = $clog2(STORE_BYTES + 1);
	localparam int AW = $clog2(STORE_BYTES);
	localparam logic [FW-1:0] FILL_MAX = FW'(STORE_BYTES);
	localparam logic [FW-1:0] PKT_N    = FW'(PACKET_BYTES);
	localparam logic [FW-1:0] FRAME_N  = FW'(5);
	localparam logic [FW-1:0] ONE      = FW'(1);

	// latched input word
	logic [1:0] cmd_q;
	logic [7:0] byte_q;

	// persistent state
	logic [FW-1:0]          fill_q;
	logic [3:0]             step_q;
	logic [31:0]            cnt_q;
	logic                   clean_q;
	logic                   rename_q;
	logic [STORE_BYTES-1:0] vld_q;
	logic [39:0]            hist_q;

	// scanner
	logic [FW-1:0]      p_q;
	logic               pend_s1;
	logic               vld_s1;
	logic               stop_q;
	win_t               win_q;
	logic [NUM_TXT-1:0] hits_q;

	// packet read index
	logic [FW-1:0] k_q;

	// ram
	logic [7:0]    rdata;
	logic [AW-1:0] raddr;
	logic [FW-1:0] wpos;
	logic [FW-1:0] fill_wr;

	// ------------------------------------------------------------------
	// store write position and read address
	assign wpos    = (fill_q >= FILL_MAX) ? '0 : fill_q;
	assign fill_wr = wpos + ONE;
	assign raddr   = ctl.scan_en ? p_q[AW-1:0] : k_q[AW-1:0];

	blup_ram #(.WIDTH(8), .DEPTH(STORE_BYTES)) u_store (
		.clk   (clk),
		.we    (ctl.write),
		.waddr (wpos[AW-1:0]),
		.wdata (byte_q),
		.raddr (raddr),
		.rdata (rdata)
	);

	// ------------------------------------------------------------------
	// scanner: one byte per cycle up to the first zero or the store end
	logic [7:0]         sbyte;
	logic               issue;
	logic               take;
	win_t               win_n;
	logic [NUM_TXT-1:0] hit_n;

	assign sbyte = vld_s1 ? rdata : 8'h00;
	assign issue = ctl.scan_en && !stop_q && (p_q < FILL_MAX);
	assign take  = pend_s1 && !stop_q;
	assign win_n = {win_q[WIN_BITS-9:0], sbyte};

	always_comb begin
		for (int t = 0; t < NUM_TXT; t++)
			hit_n[t] = txt_hit(win_n, TXT_TAB[t], TXT_LEN[t]);
	end

	// ------------------------------------------------------------------
	// frame checks on the last five written bytes (newest at [7:0])
	logic four_dens;
	logic four_fin;
	logic dens_c;
	logic fin_c;
	logic emit_c;
	logic in_finish;

	assign in_finish = (step_q == ST_FINISH);
	assign four_dens = (hist_q[39:32] == FRAME_DENS) && (hist_q[31:24] == FRAME_DENS) &&
	                   (hist_q[23:16] == FRAME_DENS) && (hist_q[15:8] == FRAME_DENS);
	assign four_fin  = (hist_q[39:32] == FRAME_FIN) && (hist_q[31:24] == FRAME_FIN) &&
	                   (hist_q[23:16] == FRAME_FIN) && (hist_q[15:8] == FRAME_FIN);
	assign dens_c = (fill_q == FRAME_N) && four_dens;
	assign fin_c  = ((fill_q == FRAME_N) && four_fin) ||
	                ((fill_q >= FRAME_N) && (hist_q[7:0] == FRAME_END) && four_fin);
	assign emit_c = (cmd_q == CMD_BYTE) && in_finish && !dens_c && !fin_c &&
	                (fill_q >= PKT_N);

	// ------------------------------------------------------------------
	// result of one input word
	logic [2:0]  tx_n;
	logic [3:0]  step_n;
	logic        done_n;
	logic [1:0]  led_n;
	logic [6:0]  dens_n;
	logic        fin_n;
	logic        clr_n;
	logic        clean_n;
	logic        rename_n;
	logic [31:0] cnt_n;
	logic        wrap_n;

	always_comb begin
		tx_n     = TX_NONE;
		step_n   = step_q;
		done_n   = 1'b0;
		led_n    = LED_NONE;
		dens_n   = DENS_NONE;
		fin_n    = 1'b0;
		clr_n    = 1'b0;
		clean_n  = clean_q;
		rename_n = rename_q;
		cnt_n    = cnt_q;
		wrap_n   = 1'b0;
		case (cmd_q)
			CMD_TICK: begin
				led_n = LED_SETUP;
				case (step_q)
					ST_START, ST_AT: begin
						tx_n = TX_ENTER_AT; step_n = ST_AT;
					end
					ST_AT_OK, ST_CLOSE: begin
						tx_n = TX_SET_STAT; step_n = ST_CLOSE;
					end
					ST_CLOSE_OK, ST_QSTAT: begin
						tx_n = TX_QRY_STAT; step_n = ST_QSTAT;
					end
					ST_QSTAT_OK, ST_QNAME: begin
						tx_n = TX_QRY_NAME; step_n = ST_QNAME;
					end
					ST_NEED_NAME, ST_SETNAME: begin
						tx_n = TX_SET_NAME; step_n = ST_SETNAME; rename_n = 1'b1;
					end
					ST_NO_NAME, ST_SETNAME_OK, ST_EXIT: begin
						tx_n = TX_EXIT_AT; step_n = ST_EXIT;
					end
					ST_FINISH: begin
						done_n = 1'b1; led_n = LED_NONE; clr_n = 1'b1;
					end
					ST_RESET: tx_n = TX_EXIT_AT;
					default: ;
				endcase
			end
			CMD_CLEAN: begin
				if (clean_q) begin
					clr_n = 1'b1; clean_n = 1'b0;
				end
			end
			CMD_CLR_CNT: cnt_n = '0;
			default: begin
				if (in_finish) begin
					// connection text, later match wins
					if (hits_q[T_CONN])   led_n = LED_CONN;
					if (hits_q[T_DISC])   led_n = LED_DISC;
					if (hits_q[T_DEVERR]) led_n = LED_CONN;
					if (hits_q[T_CONN] || hits_q[T_DISC] || hits_q[T_DEVERR])
						clean_n = 1'b1;
					if (dens_c) begin
						if (hist_q[7:0] == DENS_CODE_LOW)      dens_n = DENS_LOW;
						else if (hist_q[7:0] == DENS_CODE_MID) dens_n = DENS_MID;
						else                                   dens_n = DENS_HIGH;
						clr_n = 1'b1;
					end else if (fin_c) begin
						fin_n = 1'b1; clr_n = 1'b1;
					end else if (emit_c) begin
						cnt_n = cnt_q + 32'd1;
					end
				end else if (hits_q[T_OK]) begin
					case (step_q)
						ST_AT:      step_n = ST_AT_OK;
						ST_CLOSE:   step_n = ST_CLOSE_OK;
						ST_QNAME:   step_n = hits_q[T_DFLT] ? ST_NEED_NAME : ST_NO_NAME;
						ST_SETNAME: step_n = ST_SETNAME_OK;
						ST_EXIT:    step_n = ST_FINISH;
						ST_RESET:   step_n = ST_START;
						ST_QSTAT:   step_n = hits_q[T_STAT0] ? ST_QSTAT_OK : ST_CLOSE;
						default: ;
					endcase
					clr_n = 1'b1;
				end else begin
					if (hits_q[T_ERR])
						step_n = ST_RESET;
					wrap_n = (fill_q >= FILL_MAX);
				end
			end
		endcase
	end

	// ------------------------------------------------------------------
	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q   <= '0;
			step_q   <= ST_START;
			cnt_q    <= '0;
			clean_q  <= 1'b0;
			rename_q <= 1'b0;
			vld_q    <= '0;
			p_q      <= '0;
			pend_s1  <= 1'b0;
			stop_q   <= 1'b0;
			hits_q   <= '0;
			k_q      <= '0;
		end else begin
			pend_s1 <= issue;
			if (issue)
				p_q <= p_q + ONE;
			if (take) begin
				if (sbyte == 8'h00)
					stop_q <= 1'b1;
				else
					hits_q <= hits_q | hit_n;
			end
			if (ctl.scan_init) begin
				p_q    <= '0;
				stop_q <= 1'b0;
				hits_q <= '0;
			end
			if (ctl.write) begin
				vld_q[wpos[AW-1:0]] <= 1'b1;
				fill_q              <= fill_wr;
			end
			if (ctl.commit) begin
				step_q   <= step_n;
				cnt_q    <= cnt_n;
				clean_q  <= clean_n;
				rename_q <= rename_n;
				k_q      <= '0;
				if (clr_n) begin
					vld_q  <= '0;
					fill_q <= '0;
				end else if (wrap_n) begin
					fill_q <= '0;
				end
			end
			if (ctl.pkt_next)
				k_q <= k_q + ONE;
			if (ctl.pkt_done) begin
				vld_q  <= '0;
				fill_q <= '0;
				k_q    <= '0;
			end
		end
	end

	// ------------------------------------------------------------------
	// payload registers
	always_ff @(posedge clk) begin
		vld_s1 <= vld_q[raddr];
		if (ctl.load) begin
			cmd_q  <= cmd;
			byte_q <= rx_byte;
		end
		if (ctl.write)
			hist_q <= {hist_q[31:0], byte_q};
		if (ctl.scan_init)
			win_q <= '0;
		else if (take && sbyte != 8'h00)
			win_q <= win_n;
		if (ctl.commit) begin
			tx_command       <= tx_n;
			setup_step       <= step_n;
			setup_done       <= done_n;
			led_event        <= led_n;
			heat_density     <= dens_n;
			read_finish      <= fin_n;
			packet_byte      <= 8'h00;
			packet_valid     <= 1'b0;
			last             <= 1'b1;
			packet_count     <= cnt_n;
			rename_requested <= rename_n;
			clean_pending    <= clean_n;
		end
		if (ctl.pkt_ld) begin
			packet_byte  <= sbyte;
			packet_valid <= 1'b1;
			last         <= (k_q == fill_q - ONE);
		end
	end

	// ------------------------------------------------------------------
	// status
	assign stat.cmd       = cmd_q;
	assign stat.scan_done = stop_q || ((p_q == FILL_MAX) && !pend_s1);
	assign stat.emit      = emit_c;
	assign stat.pkt_last  = (k_q == fill_q - ONE);

endmodule

`default_nettype wire

// ----- rtl/blup_ctrl.sv -----
// ----------------------------------------------------------------------------
// blup_ctrl
// Sequencer: accept word, write and scan the store (bytes only), commit, then deliver
// one result or a packet of results.
// ----------------------------------------------------------------------------
`default_nettype none

module blup_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	output logic                    out_valid,
	input  wire logic               out_ready,
	input  wire blup_pkg::dp_stat_t stat,
	output blup_pkg::ctl_cmd_t      ctl
);

	import blup_pkg::*;

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_EXEC   = 3'd1;
	localparam logic [2:0] S_SCAN   = 3'd2;
	localparam logic [2:0] S_COMMIT = 3'd3;
	localparam logic [2:0] S_RESULT = 3'd4;
	localparam logic [2:0] S_PKT_RD = 3'd5;
	localparam logic [2:0] S_PKT_LD = 3'd6;
	localparam logic [2:0] S_PKT_OUT = 3'd7;

	logic [2:0] state_q;
	logic [2:0] state_n;

	// next state and commands
	always_comb begin
		state_n   = state_q;
		ctl       = '0;
		in_ready  = 1'b0;
		out_valid = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					ctl.load = 1'b1;
					state_n  = S_EXEC;
				end
			end
			S_EXEC: begin
				if (stat.cmd == CMD_BYTE) begin
					ctl.write     = 1'b1;
					ctl.scan_init = 1'b1;
					state_n       = S_SCAN;
				end else begin
					state_n = S_COMMIT;
				end
			end
			S_SCAN: begin
				ctl.scan_en = 1'b1;
				if (stat.scan_done)
					state_n = S_COMMIT;
			end
			S_COMMIT: begin
				ctl.commit = 1'b1;
				state_n    = stat.emit ? S_PKT_RD : S_RESULT;
			end
			S_RESULT: begin
				out_valid = 1'b1;
				if (out_ready)
					state_n = S_IDLE;
			end
			S_PKT_RD: state_n = S_PKT_LD;
			S_PKT_LD: begin
				ctl.pkt_ld = 1'b1;
				state_n    = S_PKT_OUT;
			end
			S_PKT_OUT: begin
				out_valid = 1'b1;
				if (out_ready) begin
					if (stat.pkt_last) begin
						ctl.pkt_done = 1'b1;
						state_n      = S_IDLE;
					end else begin
						ctl.pkt_next = 1'b1;
						state_n      = S_PKT_RD;
					end
				end
			end
			default: state_n = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_n;
	end

endmodule

`default_nettype wire

// ----- rtl/ble_uart_link_parser.sv -----
// ----------------------------------------------------------------------------
// ble_uart_link_parser
// Parses bytes from a radio module: AT setup handshake, connection text,
// density and finish frames, and print packets.
// ----------------------------------------------------------------------------
//  channel | signals                          | direction
//  in      | in_valid/in_ready, cmd, rx_byte  | to block
//  out     | out_valid/out_ready, result word | from block
//
//  A received byte is written to the store, which is then scanned up to the first
//  zero or the store end through the single store read port, then the result word.
//  Ticks and other commands skip the store and commit, then the result word.
//  A packet delivers every stored byte (at least PACKET_BYTES) from the store.
//  Reset empties the store at once through per-entry valid bits.
//  Input is taken only when all results of the last word have left.
// ----------------------------------------------------------------------------
`default_nettype none

module ble_uart_link_parser #(
	parameter int STORE_BYTES  = blup_pkg::STORE_BYTES_DEF,
	parameter int PACKET_BYTES = blup_pkg::PACKET_BYTES_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [1:0]  cmd,
	input  wire logic [7:0]  rx_byte,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic      [2:0]  tx_command,
	output logic      [3:0]  setup_step,
	output logic             setup_done,
	output logic      [1:0]  led_event,
	output logic      [6:0]  heat_density,
	output logic             read_finish,
	output logic      [7:0]  packet_byte,
	output logic             packet_valid,
	output logic             last,
	output logic      [31:0] packet_count,
	output logic             rename_requested,
	output logic             clean_pending
);

	import blup_pkg::*;

	ctl_cmd_t ctl;
	dp_stat_t stat;

	blup_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.stat      (stat),
		.ctl       (ctl)
	);

	blup_datapath #(
		.STORE_BYTES  (STORE_BYTES),
		.PACKET_BYTES (PACKET_BYTES)
	) u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.ctl              (ctl),
		.stat             (stat),
		.cmd              (cmd),
		.rx_byte          (rx_byte),
		.tx_command       (tx_command),
		.setup_step       (setup_step),
		.setup_done       (setup_done),
		.led_event        (led_event),
		.heat_density     (heat_density),
		.read_finish      (read_finish),
		.packet_byte      (packet_byte),
		.packet_valid     (packet_valid),
		.last             (last),
		.packet_count     (packet_count),
		.rename_requested (rename_requested),
		.clean_pending    (clean_pending)
	);

endmodule

`default_nettype wire

// ----- rtl/blup_checker.sv -----
// ----------------------------------------------------------------------------
// blup_checker
// Port-level checks on the link parser, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module blup_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       in_valid,
	input wire logic       in_ready,
	input wire logic       out_valid,
	input wire logic       out_ready,
	input wire logic [2:0] tx_command,
	input wire logic       setup_done,
	input wire logic [7:0] packet_byte,
	input wire logic       packet_valid,
	input wire logic       last
);

	import blup_pkg::*;

	// a stalled word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(packet_byte) && $stable(last))
		else $error("stalled output word changed");

	// one word in flight: never taking input while results wait
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid))
		else $error("input taken while results pending");

	// no result in the cycle right after a word is accepted
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !out_valid)
		else $error("result appeared too early");

	// non-packet results are single and final
	a_single_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !packet_valid |-> last && tx_command <= TX_EXIT_AT &&
		(!setup_done || tx_command == TX_NONE))
		else $error("bad single result");

endmodule

bind ble_uart_link_parser blup_checker u_blup_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_ready     (in_ready),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.tx_command   (tx_command),
	.setup_done   (setup_done),
	.packet_byte  (packet_byte),
	.packet_valid (packet_valid),
	.last         (last)
);

`default_nettype wire

// ----- verif/tb.sv -----
// ----------------------------------------------------------------------------
// tb - radio link parser testbench
// Walks the AT handshake, including the error and recovery path, and then
// runs connection text, density and finish frames and print packets. A
// built-in copy of the parser predicts every result word. Each word that
// leaves the block is checked field by field against that prediction. Both
// handshakes idle and stall at random.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
	import blup_pkg::*;

	localparam int STORE_N  = STORE_BYTES_DEF;
	localparam int PACKET_N = PACKET_BYTES_DEF;
	localparam int LIMIT    = 400000;

	typedef struct {
		logic [2:0]  tx;
		logic [3:0]  step;
		logic        done;
		logic [1:0]  led;
		logic [6:0]  dens;
		logic        fin;
		logic [7:0]  pb;
		logic        pv;
		logic        lst;
		logic [31:0] cnt;
		logic        ren;
		logic        cln;
	} link_word_t;

	// parser state copy, expected words and result checking
	class parser_model;
		logic [7:0]  store [STORE_N];
		int          fill;
		logic [3:0]  step;
		logic [31:0] pkts;
		bit          clean;
		bit          rename;
		link_word_t  expected_words [$];
		int          errors;
		int          words_checked;
		int          packets_seen;
		int          frames_seen;

		function new();
			wipe();
			step   = ST_START;
			pkts   = '0;
			clean  = 0;
			rename = 0;
			errors = 0;
			words_checked = 0;
			packets_seen  = 0;
			frames_seen   = 0;
		endfunction

		function void wipe();
			foreach (store[i]) store[i] = 8'h00;
			fill = 0;
		endfunction

		// C-style search: text ends at first zero byte or at store end
		function bit has_text(string s);
			int hay;
			int n;
			bit hit;
			hay = 0;
			n = s.len();
			while (hay < STORE_N && store[hay] != 8'h00) hay++;
			if (n > hay) return 0;
			for (int i = 0; i + n <= hay; i++) begin
				hit = 1;
				for (int j = 0; j < n; j++)
					if (store[i+j] != s[j]) hit = 0;
				if (hit) return 1;
			end
			return 0;
		endfunction

		function bit four_of(int start, logic [7:0] v);
			for (int k = 0; k < 4; k++)
				if (start + k >= STORE_N || store[start+k] != v) return 0;
			return 1;
		endfunction

		function void push(logic [2:0] tx, logic done, logic [1:0] led, logic [6:0] dens,
				logic fin, logic [7:0] pb, logic pv, logic lst);
			link_word_t w;
			w.tx = tx; w.step = step; w.done = done; w.led = led; w.dens = dens;
			w.fin = fin; w.pb = pb; w.pv = pv; w.lst = lst; w.cnt = pkts;
			w.ren = rename; w.cln = clean;
			expected_words.push_back(w);
		endfunction

		// accepted input word: update state, queue its results
		function void take_word(logic [1:0] c, logic [7:0] b);
			logic [2:0] tx;
			logic [1:0] led;
			logic [6:0] dens;
			logic done;
			logic fin;
			int n;
			tx = TX_NONE; led = LED_NONE; dens = DENS_NONE; done = 0; fin = 0;
			if (c == CMD_TICK) begin
				led = LED_SETUP;
				case (step)
					ST_START, ST_AT: begin tx = TX_ENTER_AT; step = ST_AT; end
					ST_AT_OK, ST_CLOSE: begin tx = TX_SET_STAT; step = ST_CLOSE; end
					ST_CLOSE_OK, ST_QSTAT: begin tx = TX_QRY_STAT; step = ST_QSTAT; end
					ST_QSTAT_OK, ST_QNAME: begin tx = TX_QRY_NAME; step = ST_QNAME; end
					ST_NEED_NAME, ST_SETNAME: begin
						tx = TX_SET_NAME; step = ST_SETNAME; rename = 1;
					end
					ST_NO_NAME, ST_SETNAME_OK, ST_EXIT: begin tx = TX_EXIT_AT; step = ST_EXIT; end
					ST_FINISH: begin done = 1; led = LED_NONE; wipe(); end
					ST_RESET: tx = TX_EXIT_AT;
					default: ;
				endcase
			end else if (c == CMD_CLEAN) begin
				if (clean) begin wipe(); clean = 0; end
			end else if (c == CMD_CLR_CNT) begin
				pkts = '0;
			end else begin
				if (fill >= STORE_N) fill = 0;
				store[fill] = b;
				fill++;
				if (step == ST_FINISH) begin
					if (has_text("CONNECTED")) begin clean = 1; led = LED_CONN; end
					if (has_text("DISCONNECTED")) begin clean = 1; led = LED_DISC; end
					if (has_text("DEVICE ERROR")) begin clean = 1; led = LED_CONN; end
					if (fill == 5 && four_of(0, FRAME_DENS)) begin
						dens = (store[4] == DENS_CODE_LOW) ? DENS_LOW :
							(store[4] == DENS_CODE_MID) ? DENS_MID : DENS_HIGH;
						frames_seen++;
						wipe();
					end else if (fill == 5 && four_of(0, FRAME_FIN)) begin
						fin = 1; frames_seen++; wipe();
					end else if (fill >= 5 && store[fill-1] == FRAME_END &&
							four_of(fill - 5, FRAME_FIN)) begin
						fin = 1; frames_seen++; wipe();
					end else if (fill >= PACKET_N) begin
						n = fill;
						pkts++;
						for (int k = 0; k < n; k++)
							push(TX_NONE, 0, led, DENS_NONE, 0, store[k], 1, k + 1 == n);
						wipe();
						return;
					end
				end else if (has_text("OK\x0D\x0A")) begin
					case (step)
						ST_AT: step = ST_AT_OK;
						ST_CLOSE: step = ST_CLOSE_OK;
						// factory default module name
						ST_QNAME: step = has_text("\x52\x46\x2D\x43\x52\x41\x5A\x59") ?
							ST_NEED_NAME : ST_NO_NAME;
						ST_SETNAME: step = ST_SETNAME_OK;
						ST_EXIT: step = ST_FINISH;
						ST_RESET: step = ST_START;
						ST_QSTAT: step = has_text("AT+STATUS=0") ? ST_QSTAT_OK : ST_CLOSE;
						default: ;
					endcase
					wipe();
				end else begin
					if (has_text("ERROR\x0D\x0A")) step = ST_RESET;
					if (fill >= STORE_N) fill = 0;
				end
			end
			push(tx, done, led, dens, fin, 8'h00, 0, 1);
		endfunction

		function void cmp(string name, logic [31:0] e, logic [31:0] a);
			if (e !== a) begin
				$error("%s: expected %0d, got %0d", name, e, a);
				errors++;
			end
		endfunction

		function void check_word(link_word_t a);
			link_word_t e;
			if (expected_words.size() == 0) begin
				$error("result word with nothing expected");
				errors++;
				return;
			end
			e = expected_words.pop_front();
			words_checked++;
			if (a.pv === 1'b1 && a.lst === 1'b1) packets_seen++;
			cmp("tx_command", 32'(e.tx), 32'(a.tx));
			cmp("setup_step", 32'(e.step), 32'(a.step));
			cmp("setup_done", 32'(e.done), 32'(a.done));
			cmp("led_event", 32'(e.led), 32'(a.led));
			cmp("heat_density", 32'(e.dens), 32'(a.dens));
			cmp("read_finish", 32'(e.fin), 32'(a.fin));
			cmp("packet_byte", 32'(e.pb), 32'(a.pb));
			cmp("packet_valid", 32'(e.pv), 32'(a.pv));
			cmp("last", 32'(e.lst), 32'(a.lst));
			cmp("packet_count", e.cnt, a.cnt);
			cmp("rename_requested", 32'(e.ren), 32'(a.ren));
			cmp("clean_pending", 32'(e.cln), 32'(a.cln));
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [1:0]  cmd;
	logic [7:0]  rx_byte;
	logic        out_valid;
	logic        out_ready;
	logic [2:0]  tx_command;
	logic [3:0]  setup_step;
	logic        setup_done;
	logic [1:0]  led_event;
	logic [6:0]  heat_density;
	logic        read_finish;
	logic [7:0]  packet_byte;
	logic        packet_valid;
	logic        last;
	logic [31:0] packet_count;
	logic        rename_requested;
	logic        clean_pending;

	parser_model model;
	int          items;
	int          cycles;
	bit          no_idle;

	ble_uart_link_parser uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .cmd(cmd), .rx_byte(rx_byte),
		.out_valid(out_valid), .out_ready(out_ready),
		.tx_command(tx_command), .setup_step(setup_step), .setup_done(setup_done),
		.led_event(led_event), .heat_density(heat_density), .read_finish(read_finish),
		.packet_byte(packet_byte), .packet_valid(packet_valid), .last(last),
		.packet_count(packet_count), .rename_requested(rename_requested),
		.clean_pending(clean_pending)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// run limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	// receiver stalls
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			out_ready <= no_idle || ($urandom_range(99) >= 36);
		end
	end

	// check every word that leaves
	always @(posedge clk) begin
		link_word_t a;
		if (arst_n && out_valid && out_ready) begin
			a.tx = tx_command; a.step = setup_step; a.done = setup_done;
			a.led = led_event; a.dens = heat_density; a.fin = read_finish;
			a.pb = packet_byte; a.pv = packet_valid; a.lst = last;
			a.cnt = packet_count; a.ren = rename_requested; a.cln = clean_pending;
			model.check_word(a);
		end
	end

	// one input word, with a random gap ahead of it
	task automatic send_word(logic [1:0] c, logic [7:0] b);
		int gap;
		gap = 0;
		if (!no_idle)
			while ($urandom_range(99) < 36 && gap < 6) gap++;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		cmd      <= c;
		rx_byte  <= b;
		do @(posedge clk); while (!in_ready);
		model.take_word(c, b);
		items++;
	endtask

	task automatic send_text(string s);
		for (int i = 0; i < s.len(); i++) send_word(CMD_BYTE, s[i]);
	endtask

	task automatic send_noise(int n, bit allow_zero);
		for (int i = 0; i < n; i++)
			send_word(CMD_BYTE, allow_zero ? 8'($urandom_range(255)) :
				8'($urandom_range(255, 1)));
	endtask

	task automatic send_frame(logic [7:0] head, logic [7:0] tail);
		repeat (4) send_word(CMD_BYTE, head);
		send_word(CMD_BYTE, tail);
	endtask

	// step the handshake through to its finished state
	task automatic reach_finish();
		int guard;
		guard = 0;
		while (model.step != ST_FINISH && guard < 300) begin
			guard++;
			case (model.step)
				ST_QSTAT: begin
					if ($urandom_range(1)) send_text("AT+STATUS=0");
					send_text("OK\x0D\x0A");
				end
				ST_QNAME: begin
					if ($urandom_range(1)) send_text("\x52\x46\x2D\x43\x52\x41\x5A\x59");
					send_text("OK\x0D\x0A");
				end
				ST_AT, ST_CLOSE, ST_SETNAME, ST_EXIT, ST_RESET: send_text("OK\x0D\x0A");
				default: send_word(CMD_TICK, 8'h00);
			endcase
		end
	endtask

	initial begin
		int r;
		model    = new();
		items    = 0;
		cycles   = 0;
		no_idle  = 0;
		arst_n   = 1'b0;
		in_valid = 1'b0;
		cmd      = CMD_BYTE;
		rx_byte  = 8'h00;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed, setup side: idle commands, error path, reset step
		send_word(CMD_CLR_CNT, 8'h00);
		send_word(CMD_CLEAN, 8'h00);
		send_word(CMD_TICK, 8'h00);
		send_word(CMD_BYTE, 8'hFF);
		send_text("ERROR\x0D\x0A");
		send_word(CMD_TICK, 8'h00);
		send_text("OK\x0D\x0A");

		// random setup traffic, one long run past the store end with no idling
		no_idle = 1;
		send_noise(STORE_N + 3, 0);
		no_idle = 0;
		while (items < 80) begin
			r = $urandom_range(99);
			if (r < 25) send_word(CMD_TICK, 8'h00);
			else if (r < 45) send_text("OK\x0D\x0A");
			else if (r < 52) send_text("ERROR\x0D\x0A");
			else if (r < 60) send_text("AT+STATUS=0\x0D\x0AOK\x0D\x0A");
			else if (r < 68) send_text("\x52\x46\x2D\x43\x52\x41\x5A\x59\x0D\x0AOK\x0D\x0A");
			else if (r < 80) send_noise($urandom_range(6, 1), 0);
			else if (r < 88) send_word(CMD_CLEAN, 8'h00);
			else if (r < 93) send_word(CMD_CLR_CNT, 8'h00);
			else send_text("OK");
		end
		reach_finish();

		// directed, after setup: tick, zero byte, densities, finish frames
		send_word(CMD_TICK, 8'h00);
		send_word(CMD_BYTE, 8'h00);
		send_word(CMD_TICK, 8'h00);
		send_frame(FRAME_DENS, DENS_CODE_LOW);
		send_frame(FRAME_DENS, DENS_CODE_MID);
		send_frame(FRAME_DENS, 8'hFF);
		send_frame(FRAME_FIN, FRAME_END);
		send_word(CMD_CLEAN, 8'h00);

		// random traffic after setup
		while (items < 210) begin
			r = $urandom_range(99);
			if (r < 12) send_word(CMD_TICK, 8'h00);
			else if (r < 20) send_text("CONNECTED");
			else if (r < 26) send_text("DISCONNECTED");
			else if (r < 30) send_text("DEVICE ERROR");
			else if (r < 38) send_word(CMD_CLEAN, 8'h00);
			else if (r < 42) send_word(CMD_CLR_CNT, 8'h00);
			else if (r < 52) begin
				if ($urandom_range(9) < 7) send_word(CMD_TICK, 8'h00);
				send_frame(FRAME_DENS, 8'($urandom_range(3)));
			end else if (r < 60) begin
				if ($urandom_range(9) < 7) send_word(CMD_TICK, 8'h00);
				send_frame(FRAME_FIN, FRAME_END);
			end else if (r < 66) begin
				send_noise($urandom_range(8), 1);
				send_frame(FRAME_FIN, FRAME_END);
			end else begin
				send_noise($urandom_range(30, 1), 1);
			end
		end
		in_valid <= 1'b0;

		while (model.expected_words.size() != 0) @(posedge clk);
		repeat (400) @(posedge clk);

		$display("covered %0d input words, %0d result words, %0d packets, %0d frames",
			items, model.words_checked, model.packets_seen, model.frames_seen);
		$display("handshake ended in step %0d, set-name issued: %0d", model.step, model.rename);
		if (model.errors == 0 && model.expected_words.size() == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule

`default_nettype wire
